@@ rtl/sts_pkg.sv @@
package sts_pkg;

  typedef enum logic [2:0] {
    STAGE_MASH    = 3'd0,
    STAGE_MASHOUT = 3'd1,
    STAGE_WAIT    = 3'd2,
    STAGE_BOIL    = 3'd3,
    STAGE_DONE    = 3'd4
  } sts_stage_e;

  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_ESC  = 2'd2;

  localparam logic [2:0] REG_MASH_LOW      = 3'd0;
  localparam logic [2:0] REG_MASH_HIGH     = 3'd1;
  localparam logic [2:0] REG_MASH_SECONDS  = 3'd2;
  localparam logic [2:0] REG_MASHOUT_THR   = 3'd3;
  localparam logic [2:0] REG_BOIL_LOW      = 3'd4;
  localparam logic [2:0] REG_BOIL_HIGH     = 3'd5;
  localparam logic [2:0] REG_BOIL_SECONDS  = 3'd6;

  localparam int unsigned TEMP_W = 14;
  localparam int unsigned SEC_W  = 16;
  localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

  localparam logic signed [TEMP_W-1:0] MASH_LOW_RST     = 14'sd2320;
  localparam logic signed [TEMP_W-1:0] MASH_HIGH_RST    = 14'sd2400;
  localparam logic        [SEC_W-1:0]  MASH_SECONDS_RST = 16'd60;
  localparam logic signed [TEMP_W-1:0] MASHOUT_THR_RST  = 14'sd2848;
  localparam logic signed [TEMP_W-1:0] BOIL_LOW_RST     = 14'sd3392;
  localparam logic signed [TEMP_W-1:0] BOIL_HIGH_RST    = 14'sd3472;
  localparam logic        [SEC_W-1:0]  BOIL_SECONDS_RST = 16'd90;

  typedef struct packed {
    logic signed [TEMP_W-1:0] mash_low;
    logic signed [TEMP_W-1:0] mash_high;
    logic        [SEC_W-1:0]  mash_seconds;
    logic signed [TEMP_W-1:0] mashout_thr;
    logic signed [TEMP_W-1:0] boil_low;
    logic signed [TEMP_W-1:0] boil_high;
    logic        [SEC_W-1:0]  boil_seconds;
  } sts_cfg_t;

  typedef struct packed {
    sts_stage_e       stage;
    logic             relay;
    logic [SEC_W-1:0] seconds;
    logic             keys_en;
  } sts_state_t;

  // packed so that heater sits in bit 0
  typedef struct packed {
    logic [SEC_W-1:0] seconds;
    logic [2:0]       stage;
    logic             heater;
  } sts_result_t;

endpackage

@@ rtl/sts_step.sv @@
module sts_step (
  input  sts_pkg::sts_cfg_t                 cfg_i,
  input  sts_pkg::sts_state_t               state_i,
  input  logic signed [sts_pkg::TEMP_W-1:0] temp_i,
  input  logic                              tick_i,
  input  logic [1:0]                        key_i,
  output sts_pkg::sts_state_t               state_o
);
  import sts_pkg::*;

  logic signed [TEMP_W-1:0] band_lo, band_hi;
  logic [SEC_W-1:0]         band_len;
  sts_state_t               st;

  always_comb begin
    st = state_i;

    // key first
    if (key_i == KEY_ESC) begin
      st.keys_en = 1'b0;
    end else if (key_i != KEY_NONE && state_i.keys_en && state_i.stage == STAGE_WAIT) begin
      st.stage   = STAGE_BOIL;
      st.seconds = '0;
    end

    if (tick_i && st.seconds != SEC_MAX) begin
      st.seconds = st.seconds + 1'b1;
    end

    if (st.stage == STAGE_BOIL) begin
      band_lo  = cfg_i.boil_low;
      band_hi  = cfg_i.boil_high;
      band_len = cfg_i.boil_seconds;
    end else begin
      band_lo  = cfg_i.mash_low;
      band_hi  = cfg_i.mash_high;
      band_len = cfg_i.mash_seconds;
    end

    case (st.stage)
      STAGE_MASH, STAGE_BOIL: begin
        if (temp_i > band_hi) st.relay = 1'b0;
        if (temp_i < band_lo) st.relay = 1'b1;  // on wins if bounds cross
        if (st.seconds > band_len) begin
          st.relay = 1'b0;
          st.stage = (st.stage == STAGE_BOIL) ? STAGE_DONE : STAGE_MASHOUT;
        end
      end
      STAGE_MASHOUT: begin
        if (temp_i > cfg_i.mashout_thr) begin
          st.relay = 1'b0;
          st.stage = STAGE_WAIT;
        end else begin
          st.relay = 1'b1;
        end
      end
      default: begin
      end
    endcase

    state_o = st;
  end

endmodule

@@ rtl/staged_thermostat_sequencer.sv @@
// Each result is registered: in the buffer head, or the second word if the head stays full.
// Throughput: one word per cycle; the two-word output buffer keeps s_axis ready
// while one result waits, and stalls input only when both words are held.
// Reset (rst_ni low, asynchronous): stage mash, relay off, counter zero, keys
// enabled, all registers at their default values, output buffer empty.
module staged_thermostat_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // temp_sample[13:0], second_tick, key_event[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // heater_on, current_stage[2:0], elapsed_seconds[15:0]
);
  import sts_pkg::*;

  sts_cfg_t    cfg_q;
  sts_state_t  state_q, state_d;
  sts_result_t res, out_q, out_d, skid_q, skid_d;
  logic        out_vq, out_vd, skid_vq, skid_vd;
  logic        in_fire, out_fire;

  assign s_axis_tready_o = !skid_vq;
  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = {4'b0, out_q};
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_vq && m_axis_tready_i;

  sts_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .temp_i  (s_axis_tdata_i[13:0]),
    .tick_i  (s_axis_tdata_i[14]),
    .key_i   (s_axis_tdata_i[16:15]),
    .state_o (state_d)
  );

  assign res.seconds = state_d.seconds;
  assign res.stage   = state_d.stage;
  assign res.heater  = state_d.relay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mash_low     <= MASH_LOW_RST;
      cfg_q.mash_high    <= MASH_HIGH_RST;
      cfg_q.mash_seconds <= MASH_SECONDS_RST;
      cfg_q.mashout_thr  <= MASHOUT_THR_RST;
      cfg_q.boil_low     <= BOIL_LOW_RST;
      cfg_q.boil_high    <= BOIL_HIGH_RST;
      cfg_q.boil_seconds <= BOIL_SECONDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MASH_LOW:     cfg_q.mash_low     <= cfg_wdata_i[13:0];
        REG_MASH_HIGH:    cfg_q.mash_high    <= cfg_wdata_i[13:0];
        REG_MASH_SECONDS: cfg_q.mash_seconds <= cfg_wdata_i;
        REG_MASHOUT_THR:  cfg_q.mashout_thr  <= cfg_wdata_i[13:0];
        REG_BOIL_LOW:     cfg_q.boil_low     <= cfg_wdata_i[13:0];
        REG_BOIL_HIGH:    cfg_q.boil_high    <= cfg_wdata_i[13:0];
        REG_BOIL_SECONDS: cfg_q.boil_seconds <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage   <= STAGE_MASH;
      state_q.relay   <= 1'b0;
      state_q.seconds <= '0;
      state_q.keys_en <= 1'b1;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // two-word output buffer: out is the head, skid the second word
  always_comb begin
    out_vd  = out_vq;
    skid_vd = skid_vq;
    out_d   = out_q;
    skid_d  = skid_q;
    if (out_fire) begin
      if (skid_vq) begin
        out_d   = skid_q;
        skid_vd = 1'b0;
      end else begin
        out_vd = 1'b0;
      end
    end
    if (in_fire) begin
      if (!out_vd) begin
        out_vd = 1'b1;
        out_d  = res;
      end else begin
        skid_vd = 1'b1;
        skid_d  = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      out_vq  <= out_vd;
      skid_vq <= skid_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vq |-> out_vq)
    else $error("skid word held with empty head");

  a_keys_stay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.keys_en |=> !state_q.keys_en)
    else $error("keys re-enabled without reset");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stage == STAGE_DONE |=> state_q.stage == STAGE_DONE)
    else $error("left done stage");

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_vq)
    else $error("accepted word produced no result");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && !out_fire) |=> out_vq)
    else $error("pending result lost");
`endif

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam logic [1:0]  KEY_PRESS   = 2'd1;
  localparam logic [1:0]  KEY_ALT     = 2'd3;  // code three acts as an ordinary key
  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  localparam int unsigned QUIET_LIMIT = 200;
  localparam int unsigned PRINT_CAP   = 40;

  typedef struct {
    bit                       is_cfg;
    logic [2:0]               idx;
    logic [15:0]              wdata;
    logic signed [TEMP_W-1:0] temp;
    logic                     tick;
    logic [1:0]               key;
    bit                       typed;
    sts_result_t              want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] in_data;   // temp_sample[13:0], second_tick, key_event[1:0]
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_data;  // heater_on, current_stage[2:0], elapsed_seconds[15:0]

  staged_thermostat_sequencer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  // brew schedule as the block should see it
  logic signed [TEMP_W-1:0] mash_lo, mash_hi, mo_thr, boil_lo, boil_hi;
  logic [SEC_W-1:0]         mash_len, boil_len;
  sts_stage_e               brew_stage;
  logic                     heat;
  logic [SEC_W-1:0]         secs;
  logic                     keys_ok;

  sts_result_t  status_due_q[$];
  plan_row_t    brew_plan[$];
  int unsigned  status_errors;
  int unsigned  quiet_cycles;
  bit           tx_steady;
  bit           rx_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic band_ends(input logic signed [TEMP_W-1:0] t, lo, hi,
                                     input logic [SEC_W-1:0] len);
    if (t > hi) heat = 1'b0;
    if (t < lo) heat = 1'b1;  // on wins when the band is inverted
    if (secs > len) begin
      heat = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sts_result_t advance_brew(input logic signed [TEMP_W-1:0] t,
                                               input logic tick, input logic [1:0] key);
    sts_result_t r;
    if (key == KEY_ESC) begin
      keys_ok = 1'b0;
    end else if (key != KEY_NONE && keys_ok && brew_stage == STAGE_WAIT) begin
      brew_stage = STAGE_BOIL;
      secs = '0;
    end
    if (tick && secs != SEC_MAX) secs = secs + 1'b1;
    case (brew_stage)
      STAGE_MASH: begin
        if (band_ends(t, mash_lo, mash_hi, mash_len)) brew_stage = STAGE_MASHOUT;
      end
      STAGE_MASHOUT: begin
        if (t > mo_thr) begin
          heat = 1'b0;
          brew_stage = STAGE_WAIT;
        end else begin
          heat = 1'b1;
        end
      end
      STAGE_BOIL: begin
        if (band_ends(t, boil_lo, boil_hi, boil_len)) brew_stage = STAGE_DONE;
      end
      default: ;
    endcase
    r.heater  = heat;
    r.stage   = brew_stage;
    r.seconds = secs;
    return r;
  endfunction

  function automatic sts_result_t status(input logic h, input sts_stage_e st,
                                         input logic [SEC_W-1:0] s);
    sts_result_t r;
    r.heater  = h;
    r.stage   = st;
    r.seconds = s;
    return r;
  endfunction

  function automatic void add_word(input logic signed [TEMP_W-1:0] t, input logic tk,
                                   input logic [1:0] k, input bit typed = 1'b0,
                                   input sts_result_t want = '0);
    plan_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, wdata: '0, temp: t, tick: tk, key: k,
          typed: typed, want: want};
    brew_plan.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [2:0] i, input logic [15:0] v);
    plan_row_t r;
    r = '{is_cfg: 1'b1, idx: i, wdata: v, temp: '0, tick: 1'b0, key: KEY_NONE,
          typed: 1'b0, want: '0};
    brew_plan.push_back(r);
  endfunction

  function automatic logic signed [TEMP_W-1:0] any_temp();
    return TEMP_W'(int'($urandom_range(0, 9215)) - 1024);
  endfunction

  // mostly samples around the band edges, some from the whole range
  function automatic logic signed [TEMP_W-1:0] temp_near(input int lo, input int hi);
    int a, b;
    if ($urandom_range(0, 3) == 0) return any_temp();
    a = ((lo < hi) ? lo : hi) - 40;
    b = ((lo < hi) ? hi : lo) + 40;
    if (a < -1024) a = -1024;
    if (b > 8191) b = 8191;
    return TEMP_W'(a + int'($urandom_range(0, b - a)));
  endfunction

  function automatic logic [1:0] key_noise();
    case ($urandom_range(0, 5))
      4:       return KEY_PRESS;
      5:       return KEY_ALT;
      default: return KEY_NONE;
    endcase
  endfunction

  task automatic pick_band(output logic signed [TEMP_W-1:0] lo, hi, input int kind);
    int a;
    case (kind)
      0: begin
        a  = int'($urandom_range(0, 8924)) - 1024;
        lo = TEMP_W'(a);
        hi = TEMP_W'(a + int'($urandom_range(0, 191)));
      end
      1: begin
        a  = int'($urandom_range(0, 8924)) - 1024;
        hi = TEMP_W'(a);
        lo = TEMP_W'(a + int'($urandom_range(1, 200)));
      end
      2: begin
        lo = -14'sd1024;
        hi = 14'sd8191;
      end
      3: begin
        lo = any_temp();
        hi = lo;
      end
      4: begin
        lo = any_temp();
        hi = any_temp();
      end
      default: begin
        lo = 14'sd8191;
        hi = -14'sd1024;
      end
    endcase
  endtask

  task automatic pick_pace();
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic report_status_error(input string what);
    status_errors++;
    if (status_errors <= PRINT_CAP) $display("%0t ns: %s", $time, what);
  endtask

  // registers only change with the pipe drained
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MASH_LOW:     mash_lo  = val[TEMP_W-1:0];
      REG_MASH_HIGH:    mash_hi  = val[TEMP_W-1:0];
      REG_MASH_SECONDS: mash_len = val;
      REG_MASHOUT_THR:  mo_thr   = val[TEMP_W-1:0];
      REG_BOIL_LOW:     boil_lo  = val[TEMP_W-1:0];
      REG_BOIL_HIGH:    boil_hi  = val[TEMP_W-1:0];
      REG_BOIL_SECONDS: boil_len = val;
      default: ;
    endcase
  endtask

  // upper two data bits are don't-care for temperature registers
  task automatic write_temp_reg(input logic [2:0] idx, input logic signed [TEMP_W-1:0] v);
    write_reg(idx, {2'($urandom_range(0, 3)), v});
  endtask

  task automatic send_word(input logic signed [TEMP_W-1:0] t, input logic tick,
                           input logic [1:0] key, input bit typed = 1'b0,
                           input sts_result_t want = '0);
    int unsigned gap;
    sts_result_t pred;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= {7'd0, key, tick, t};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    pred = advance_brew(t, tick, key);
    status_due_q.push_back(typed ? want : pred);
  endtask

  // result side
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    sts_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = out_data[19:0];
      if (status_due_q.size() == 0) begin
        report_status_error($sformatf("unexpected word %h", out_data));
      end else begin
        want = status_due_q.pop_front();
        if (got.heater !== want.heater)
          report_status_error($sformatf("heater_on %b, want %b", got.heater, want.heater));
        if (got.stage !== want.stage)
          report_status_error($sformatf("current_stage %0d, want %0d", got.stage,
                                        want.stage));
        if (got.seconds !== want.seconds)
          report_status_error($sformatf("elapsed_seconds %0d, want %0d", got.seconds,
                                        want.seconds));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [TEMP_W-1:0] lo, hi, thr;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    status_errors = 0;
    mash_lo    = MASH_LOW_RST;
    mash_hi    = MASH_HIGH_RST;
    mash_len   = MASH_SECONDS_RST;
    mo_thr     = MASHOUT_THR_RST;
    boil_lo    = BOIL_LOW_RST;
    boil_hi    = BOIL_HIGH_RST;
    boil_len   = BOIL_SECONDS_RST;
    brew_stage = STAGE_MASH;
    heat       = 1'b0;
    secs       = '0;
    keys_ok    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mash band edges at the default bounds, keys ignored outside wait
    add_word(14'sd2000, 1'b0, KEY_NONE, 1'b1, status(1'b1, STAGE_MASH, 16'd0));
    add_word(14'sd2400, 1'b1, KEY_PRESS, 1'b1, status(1'b1, STAGE_MASH, 16'd1));
    add_word(14'sd2401, 1'b0, KEY_NONE, 1'b1, status(1'b0, STAGE_MASH, 16'd1));
    add_word(14'sd2320, 1'b1, KEY_ALT, 1'b1, status(1'b0, STAGE_MASH, 16'd2));
    add_word(14'sd2319, 1'b0, KEY_NONE, 1'b1, status(1'b1, STAGE_MASH, 16'd2));
    add_word(14'sd8191, 1'b1, KEY_NONE, 1'b1, status(1'b0, STAGE_MASH, 16'd3));
    add_word(-14'sd1024, 1'b1, KEY_NONE, 1'b1, status(1'b1, STAGE_MASH, 16'd4));
    // inverted band at the extremes: the on test wins in between
    add_cfg(REG_MASH_LOW, 16'h1FFF);
    add_cfg(REG_MASH_HIGH, 16'hFC00);
    add_word(14'sd8191, 1'b0, KEY_NONE, 1'b1, status(1'b0, STAGE_MASH, 16'd4));
    add_word(14'sd4000, 1'b0, KEY_NONE, 1'b1, status(1'b1, STAGE_MASH, 16'd4));
    add_word(-14'sd1024, 1'b1, KEY_NONE, 1'b1, status(1'b1, STAGE_MASH, 16'd5));
    add_cfg(REG_UNUSED, 16'hFFFF);
    add_word(14'sd8191, 1'b0, KEY_NONE, 1'b1, status(1'b0, STAGE_MASH, 16'd5));
    add_cfg(REG_MASH_SECONDS, 16'hFFFF);
    add_word(14'sd3000, 1'b1, KEY_ALT);
    add_word(14'sd0, 1'b0, KEY_PRESS);
    foreach (brew_plan[i]) begin
      if (brew_plan[i].is_cfg)
        write_reg(brew_plan[i].idx, brew_plan[i].wdata);
      else
        send_word(brew_plan[i].temp, brew_plan[i].tick, brew_plan[i].key,
                  brew_plan[i].typed, brew_plan[i].want);
    end

    // mash hysteresis under several bands; the stage cannot end yet
    for (int k = 0; k < 6; k++) begin
      pick_band(lo, hi, k);
      write_temp_reg(REG_MASH_LOW, lo);
      write_temp_reg(REG_MASH_HIGH, hi);
      pick_pace();
      repeat (55) send_word(temp_near(lo, hi), 1'($urandom_range(0, 1)), key_noise());
    end

    // back-to-back words at full rate on both sides
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (100) send_word(any_temp(), 1'b1, key_noise());

    // mash ends; the end forces the relay off over a cold sample
    write_reg(REG_MASH_SECONDS, 16'd0);
    pick_pace();
    send_word(-14'sd1024, 1'($urandom_range(0, 1)), key_noise());

    // mash-out: unreachable threshold, then a random one, then the bottom
    write_temp_reg(REG_MASHOUT_THR, 14'sd8191);
    repeat (50) send_word(any_temp(), 1'($urandom_range(0, 1)), key_noise());
    thr = TEMP_W'(int'($urandom_range(0, 9000)) - 1023);
    write_temp_reg(REG_MASHOUT_THR, thr);
    pick_pace();
    repeat (60)
      send_word(($urandom_range(0, 7) == 0) ? thr
                  : TEMP_W'(int'($urandom_range(0, int'(thr) + 1024)) - 1024),
                1'($urandom_range(0, 1)), key_noise());
    write_temp_reg(REG_MASHOUT_THR, -14'sd1024);
    repeat (8) send_word(-14'sd1024, 1'($urandom_range(0, 1)), key_noise());
    send_word(TEMP_W'(int'($urandom_range(0, 9214)) - 1023), 1'($urandom_range(0, 1)),
              KEY_NONE);

    // wait holds the relay until an ordinary key starts the boil
    write_reg(REG_BOIL_SECONDS, 16'hFFFF);
    pick_pace();
    repeat (100) send_word(any_temp(), 1'($urandom_range(0, 1)), KEY_NONE);
    send_word(any_temp(), 1'($urandom_range(0, 1)), $urandom_range(0, 1) ? KEY_PRESS : KEY_ALT);

    for (int k = 0; k < 6; k++) begin
      pick_band(lo, hi, k);
      write_temp_reg(REG_BOIL_LOW, lo);
      write_temp_reg(REG_BOIL_HIGH, hi);
      pick_pace();
      repeat (90) send_word(temp_near(lo, hi), 1'($urandom_range(0, 1)), key_noise());
    end

    // boil length equal to the count: ends on the next tick
    write_reg(REG_BOIL_SECONDS, secs);
    pick_pace();
    while (brew_stage != STAGE_DONE)
      send_word(temp_near(lo, hi), 1'($urandom_range(0, 1)), key_noise());

    write_reg(REG_BOIL_SECONDS, 16'd0);
    pick_pace();
    repeat (150) send_word(any_temp(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));

    in_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (status_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sts_pkg.sv
rtl/sts_step.sv
rtl/staged_thermostat_sequencer.sv
sim/tb.sv
